FILE: rtl/core/adl_pkg.sv
package adl_pkg;

    localparam int DATA_W             = 32;
    localparam int SUM_W              = 16;
    localparam int BYTE_W             = 8;
    localparam int MAX_BYTES          = 8;
    localparam int BYTES_PER_WORD_DEF = 4;
    localparam int MOD_PRIME          = 65521;
    localparam int BYTE_MAX           = 255;

    // 2^16 mod 65521: weight of each unit above bit 15 when folding
    localparam int FOLD_FACTOR        = (1 << SUM_W) - MOD_PRIME;

    // checksum of a message with no data
    localparam logic [DATA_W-1:0] EMPTY_CHECKSUM = DATA_W'(1);

endpackage

FILE: rtl/core/adl_sum_update.sv
// One word's worth of running-sum update, written in closed form:
//   low'  = low  + sum(b_i)
//   high' = high + N*low + sum((N-i)*b_i)
// each reduced modulo the prime: low with one conditional subtract, high with one fold and one conditional subtract.
module adl_sum_update
    import adl_pkg::*;
#(
    parameter int BYTES_PER_WORD = BYTES_PER_WORD_DEF
)
(
    input  logic [DATA_W-1:0] data_word,
    input  logic [SUM_W-1:0]  low_cur,
    input  logic [SUM_W-1:0]  high_cur,
    output logic [SUM_W-1:0]  low_new,
    output logic [SUM_W-1:0]  high_new
);

    localparam int AccMax   = (BYTES_PER_WORD + 1) * (MOD_PRIME - 1)
                            + ((BYTES_PER_WORD * (BYTES_PER_WORD + 1)) / 2) * BYTE_MAX;
    localparam int AccW     = $clog2(AccMax + 1);
    localparam int ByteSumW = $clog2(BYTES_PER_WORD * BYTE_MAX + 1);
    localparam int PadW     = MAX_BYTES * BYTE_W;

    logic [PadW-1:0]     padded;
    logic [ByteSumW-1:0] byte_sum;
    logic [AccW-1:0]     weighted;
    logic [SUM_W:0]      low_acc;
    logic [AccW-1:0]     high_acc;
    logic [SUM_W:0]      high_fold;

    // bytes beyond the data word count as zero bytes
    assign padded = {{(PadW - DATA_W){1'b0}}, data_word};

    always_comb
    begin
        byte_sum = '0;
        weighted = '0;
        for (int i = 0; i < BYTES_PER_WORD; i++)
        begin
            byte_sum = byte_sum + ByteSumW'(padded[BYTE_W*i +: BYTE_W]);
            weighted = weighted
                     + AccW'(padded[BYTE_W*i +: BYTE_W]) * AccW'(BYTES_PER_WORD - i);
        end
    end

    assign low_acc = {1'b0, low_cur} + (SUM_W+1)'(byte_sum);
    assign low_new = (low_acc >= (SUM_W+1)'(MOD_PRIME))
                   ? SUM_W'(low_acc - (SUM_W+1)'(MOD_PRIME))
                   : SUM_W'(low_acc);

    assign high_acc = AccW'(high_cur) + AccW'(low_cur) * AccW'(BYTES_PER_WORD) + weighted;

    // fold the bits above 15 back in, then at most one subtract remains
    assign high_fold = (SUM_W+1)'(high_acc[SUM_W-1:0])
                     + (SUM_W+1)'(high_acc[AccW-1:SUM_W]) * (SUM_W+1)'(FOLD_FACTOR);
    assign high_new  = (high_fold >= (SUM_W+1)'(MOD_PRIME))
                     ? SUM_W'(high_fold - (SUM_W+1)'(MOD_PRIME))
                     : SUM_W'(high_fold);

endmodule

FILE: rtl/core/adler32_word_checksum_unit.sv
// Word-fed Adler-32 variant checksum (both sums start at zero).
// A beat is registered in the input stage, its checksum in the result stage.
// Throughput: one word per cycle unless a last/empty beat waits on a held result.
// A stalled result holds in the output register while the next word is still taken.
// Reset (rst_n low, asynchronous): both sums clear to zero, both stages empty.
// Sums clear after every last word and every empty-message beat.
module adler32_word_checksum_unit
    import adl_pkg::*;
#(
    parameter int BYTES_PER_WORD = BYTES_PER_WORD_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] data_word,
    input  logic              last_word,
    input  logic              empty_message,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] checksum
);

    // input stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [DATA_W-1:0] s1_data_reg;
    logic              s1_last_reg;
    logic              s1_empty_reg;

    // running sums
    logic [SUM_W-1:0]  low_sum_reg;
    logic [SUM_W-1:0]  low_sum_next;
    logic [SUM_W-1:0]  high_sum_reg;
    logic [SUM_W-1:0]  high_sum_next;
    logic [SUM_W-1:0]  low_upd;
    logic [SUM_W-1:0]  high_upd;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] checksum_reg;
    logic [DATA_W-1:0] checksum_next;

    logic              s1_emits;
    logic              s1_adv;
    logic              in_take;
    logic              out_take;

    adl_sum_update #(
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_sum_update (
        .data_word (s1_data_reg),
        .low_cur   (low_sum_reg),
        .high_cur  (high_sum_reg),
        .low_new   (low_upd),
        .high_new  (high_upd)
    );

    assign out_take = out_valid_reg && out_ready;

    // a last or empty beat needs the result register free; others retire freely
    assign s1_emits = s1_last_reg || s1_empty_reg;
    assign s1_adv   = s1_valid_reg && (!s1_emits || !out_valid_reg || out_ready);

    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        low_sum_next   = low_sum_reg;
        high_sum_next  = high_sum_reg;
        out_valid_next = out_valid_reg;
        checksum_next  = checksum_reg;

        // drop the taken result first, a new one may land in the same cycle
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
            if (s1_empty_reg)
            begin
                low_sum_next   = '0;
                high_sum_next  = '0;
                out_valid_next = 1'b1;
                checksum_next  = EMPTY_CHECKSUM;
            end
            else if (s1_last_reg)
            begin
                low_sum_next   = '0;
                high_sum_next  = '0;
                out_valid_next = 1'b1;
                checksum_next  = {high_upd, low_upd};
            end
            else
            begin
                low_sum_next   = low_upd;
                high_sum_next  = high_upd;
            end
        end

        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            low_sum_reg   <= '0;
            high_sum_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            low_sum_reg   <= low_sum_next;
            high_sum_reg  <= high_sum_next;
        end
    end

    // payload registers: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg  <= data_word;
            s1_last_reg  <= last_word;
            s1_empty_reg <= empty_message;
        end
        checksum_reg <= checksum_next;
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

`ifndef NO_ASSERTIONS
    // sums stay fully reduced
    a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (low_sum_reg < SUM_W'(MOD_PRIME)) && (high_sum_reg < SUM_W'(MOD_PRIME)))
        else $error("running sum not reduced modulo the prime");

    // end of message clears both sums
    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_emits) |=> (low_sum_reg == '0) && (high_sum_reg == '0))
        else $error("sums not cleared after message end");

    // an empty-message beat yields checksum one
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_empty_reg) |=> out_valid_reg && (checksum_reg == EMPTY_CHECKSUM))
        else $error("empty message did not produce checksum one");

    // input stalls only behind a last or empty beat whose result register is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_emits && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");
`endif

endmodule
